// ===== rtl/core/idb_pkg.sv =====
// Shared types and constants for the input debounce and button classifier.
`default_nettype none
package idb_pkg;

  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE_MS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DCLICK_MS   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_MS     = 2'd2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_MS_RESET = 16'd50;
  localparam logic [CFG_BITS-1:0] DCLICK_MS_RESET   = 16'd300;
  localparam logic [CFG_BITS-1:0] HOLD_MS_RESET     = 16'd1000;

  // Request kinds carried in tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_DOWN     = 2'd1,
    BTN_DOUBLE   = 2'd2,
    BTN_HELD     = 2'd3
  } btn_mode_t;

  // Per-request strobes from the input stage to the update units
  typedef struct packed {
    logic sample;
    logic clear;
  } idb_step_t;

endpackage
`default_nettype wire

// ===== rtl/core/idb_lane_bank.sv =====
// Debounce lanes with per-input lockout timers and the sticky change mask.
`default_nettype none
module idb_lane_bank #(
  parameter int NUM_INPUTS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire idb_pkg::idb_step_t           step,
  input  wire logic [TIME_BITS-1:0]         now_ms,
  input  wire logic [NUM_INPUTS-1:0]        raw_levels,
  input  wire logic [idb_pkg::CFG_BITS-1:0] debounce_ms,
  output logic      [NUM_INPUTS-1:0]        stable_next,
  output logic      [NUM_INPUTS-1:0]        mask_report,
  output logic                              flag_report
);

  logic [NUM_INPUTS-1:0] stable;
  logic [NUM_INPUTS-1:0] sticky;
  logic                  changed;
  logic [TIME_BITS-1:0]  last_accept [NUM_INPUTS];
  logic [NUM_INPUTS-1:0] take;
  logic [TIME_BITS-1:0]  lockout;

  assign lockout = TIME_BITS'(debounce_ms);

  // One compare per lane, elapsed time taken modulo 2^TIME_BITS
  always_comb begin
    for (int i = 0; i < NUM_INPUTS; i++) begin
      take[i] = step.sample && (raw_levels[i] != stable[i]) &&
                ((now_ms - last_accept[i]) >= lockout);
    end
  end

  always_comb begin
    stable_next = stable ^ take;
    mask_report = sticky | take;
    flag_report = changed | (|take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable  <= '1;
      sticky  <= '0;
      changed <= 1'b0;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        last_accept[i] <= '0;
      end
    end else begin
      stable <= stable_next;
      for (int i = 0; i < NUM_INPUTS; i++) begin
        if (take[i]) begin
          last_accept[i] <= now_ms;
        end
      end
      if (step.clear) begin
        sticky  <= '0;
        changed <= 1'b0;
      end else begin
        sticky  <= mask_report;
        changed <= flag_report;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/idb_button.sv =====
// Button classifier: released, pressed, double click and held.
`default_nettype none
module idb_button #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire idb_pkg::idb_step_t           step,
  input  wire logic [TIME_BITS-1:0]         now_ms,
  input  wire logic                         button_level,
  input  wire logic [idb_pkg::CFG_BITS-1:0] dclick_ms,
  input  wire logic [idb_pkg::CFG_BITS-1:0] hold_ms,
  output idb_pkg::btn_mode_t                mode_next,
  output logic                              pressed_next
);

  idb_pkg::btn_mode_t   mode;
  logic                 pressed_flag;
  logic [TIME_BITS-1:0] press_start;
  logic [TIME_BITS-1:0] release_at;
  logic                 down;
  logic                 start_press;
  logic                 end_press;

  assign down = ~button_level;

  always_comb begin
    mode_next    = mode;
    pressed_next = pressed_flag;
    start_press  = 1'b0;
    end_press    = 1'b0;
    if (step.sample) begin
      unique case (mode)
        idb_pkg::BTN_RELEASED: begin
          if (down) begin
            start_press  = 1'b1;
            pressed_next = 1'b1;
            if ((now_ms - release_at) < TIME_BITS'(dclick_ms)) begin
              mode_next = idb_pkg::BTN_DOUBLE;
            end else begin
              mode_next = idb_pkg::BTN_DOWN;
            end
          end
        end
        idb_pkg::BTN_DOWN: begin
          if (down) begin
            if ((now_ms - press_start) >= TIME_BITS'(hold_ms)) begin
              mode_next = idb_pkg::BTN_HELD;
            end
          end else begin
            end_press = 1'b1;
          end
        end
        idb_pkg::BTN_DOUBLE,
        idb_pkg::BTN_HELD: begin
          // hold the mode while down; double click never turns into held
          if (!down) begin
            end_press = 1'b1;
          end
        end
      endcase
      if (end_press) begin
        mode_next    = idb_pkg::BTN_RELEASED;
        pressed_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= idb_pkg::BTN_RELEASED;
      pressed_flag <= 1'b0;
      press_start  <= '0;
      release_at   <= '0;
    end else begin
      mode         <= mode_next;
      pressed_flag <= pressed_next;
      if (start_press) begin
        press_start <= now_ms;
      end
      if (end_press) begin
        release_at <= now_ms;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/input_debounce_button_classifier.sv =====
// Top level: input register, config registers, update units and result register.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: now_ms, raw_levels, button_level; tuser: command
//  m_*      out  m_tvalid/m_tready  tdata: stable_levels, changed_mask, change_flag,
//                                          button_state, button_flag
//  cfg_*    in   cfg_we             cfg_index, cfg_wdata (no read-back)
//
// One request per cycle sustained while m_tready stays high; each request gives one result:
// it is held in the input register, then the lane and button update into the result register.
// Synchronous reset clears the lanes to all ones, timers and masks to zero, button released,
// config to 50 / 300 / 1000 ms. A stalled result holds; the input register still takes a
// request while the result register drains in the same cycle.
`default_nettype none
module input_debounce_button_classifier #(
  parameter int NUM_INPUTS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // now_ms, raw_levels, button_level, zero pad (lowest bit up)
  input  wire logic [((TIME_BITS+NUM_INPUTS+8)/8)*8-1:0] s_tdata,
  // command
  input  wire logic                             s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // stable_levels, changed_mask, change_flag, button_state, button_flag, zero pad
  output logic      [((2*NUM_INPUTS+4+7)/8)*8-1:0] m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [idb_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [idb_pkg::CFG_BITS-1:0]     cfg_wdata
);

  localparam int OUT_BITS = 2*NUM_INPUTS + 4;
  localparam int OUT_W    = ((OUT_BITS+7)/8)*8;

  logic                       in_valid;
  logic                       in_cmd;
  logic [TIME_BITS-1:0]       in_now;
  logic [NUM_INPUTS-1:0]      in_raw;
  logic                       in_btn;
  logic                       advance;
  idb_pkg::idb_step_t         step;

  logic [idb_pkg::CFG_BITS-1:0] debounce_ms;
  logic [idb_pkg::CFG_BITS-1:0] dclick_ms;
  logic [idb_pkg::CFG_BITS-1:0] hold_ms;

  logic [NUM_INPUTS-1:0]      stable_next;
  logic [NUM_INPUTS-1:0]      mask_report;
  logic                       flag_report;
  idb_pkg::btn_mode_t         mode_next;
  logic                       pressed_next;

  logic                       out_valid;
  logic [OUT_BITS-1:0]        out_data;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  assign step.sample = advance && (in_cmd == idb_pkg::CMD_SAMPLE);
  assign step.clear  = advance && (in_cmd == idb_pkg::CMD_READ);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= idb_pkg::DEBOUNCE_MS_RESET;
      dclick_ms   <= idb_pkg::DCLICK_MS_RESET;
      hold_ms     <= idb_pkg::HOLD_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        idb_pkg::REG_DEBOUNCE_MS: debounce_ms <= cfg_wdata;
        idb_pkg::REG_DCLICK_MS:   dclick_ms   <= cfg_wdata;
        idb_pkg::REG_HOLD_MS:     hold_ms     <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser;
      in_now <= s_tdata[TIME_BITS-1:0];
      in_raw <= s_tdata[TIME_BITS+NUM_INPUTS-1:TIME_BITS];
      in_btn <= s_tdata[TIME_BITS+NUM_INPUTS];
    end
  end

  idb_lane_bank #(
    .NUM_INPUTS(NUM_INPUTS),
    .TIME_BITS (TIME_BITS)
  ) u_lanes (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .now_ms     (in_now),
    .raw_levels (in_raw),
    .debounce_ms(debounce_ms),
    .stable_next(stable_next),
    .mask_report(mask_report),
    .flag_report(flag_report)
  );

  idb_button #(
    .TIME_BITS(TIME_BITS)
  ) u_button (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .now_ms      (in_now),
    .button_level(in_btn),
    .dclick_ms   (dclick_ms),
    .hold_ms     (hold_ms),
    .mode_next   (mode_next),
    .pressed_next(pressed_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {pressed_next, mode_next, flag_report, mask_report, stable_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule
`default_nettype wire

// ===== tb/input_debounce_button_classifier_tb.sv =====
// Self-checking testbench for the input debouncer and button classifier stream block.
`default_nettype none
module input_debounce_button_classifier_tb;

  localparam int LANES = 12;
  // No register sits at this index
  localparam logic [idb_pkg::CFG_IDX_BITS-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic               btn_flag;
    idb_pkg::btn_mode_t btn_state;
    logic               chg_flag;
    logic [11:0]        chg_mask;
    logic [11:0]        stable;
  } status_word_t;

  // Tracks the debounced lanes and button mode; holds the status words still owed.
  class debounce_tracker;
    logic [15:0]        debounce_ms;
    logic [15:0]        dclick_ms;
    logic [15:0]        hold_ms;
    logic [11:0]        stable_q;
    logic [31:0]        accept_t[LANES];
    logic [11:0]        sticky;
    logic               chg;
    idb_pkg::btn_mode_t mode;
    logic [31:0]        press_t;
    logic [31:0]        release_t;
    logic               pflag;
    status_word_t       expected_status[$];
    int                 failures;

    function new();
      int i;
      debounce_ms = idb_pkg::DEBOUNCE_MS_RESET;
      dclick_ms   = idb_pkg::DCLICK_MS_RESET;
      hold_ms     = idb_pkg::HOLD_MS_RESET;
      stable_q    = '1;
      for (i = 0; i < LANES; i++) accept_t[i] = '0;
      sticky    = '0;
      chg       = 1'b0;
      mode      = idb_pkg::BTN_RELEASED;
      press_t   = '0;
      release_t = '0;
      pflag     = 1'b0;
      failures  = 0;
    endfunction

    function void write_reg(logic [idb_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [idb_pkg::CFG_BITS-1:0] val);
      if (idx == idb_pkg::REG_DEBOUNCE_MS) debounce_ms = val;
      else if (idx == idb_pkg::REG_DCLICK_MS) dclick_ms = val;
      else if (idx == idb_pkg::REG_HOLD_MS) hold_ms = val;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    function void note_request(logic cmd, logic [31:0] now, logic [11:0] raw, logic btn);
      status_word_t want;
      logic [11:0]  next;
      logic [11:0]  diff;
      logic [31:0]  gap;
      logic         pressed;
      int           i;
      if (cmd == idb_pkg::CMD_READ) begin
        want.chg_mask = sticky;
        want.chg_flag = chg;
        sticky = '0;
        chg    = 1'b0;
      end else begin
        next = stable_q;
        for (i = 0; i < LANES; i++) begin
          gap = now - accept_t[i];
          if (raw[i] != stable_q[i] && gap >= {16'd0, debounce_ms}) begin
            accept_t[i] = now;
            next[i]     = ~next[i];
          end
        end
        diff = next ^ stable_q;
        if (diff != '0) begin
          sticky = sticky | diff;
          chg    = 1'b1;
        end
        stable_q = next;

        pressed = (btn == 1'b0);
        if (pressed && mode == idb_pkg::BTN_RELEASED) begin
          mode    = idb_pkg::BTN_DOWN;
          press_t = now;
          pflag   = 1'b1;
          gap     = now - release_t;
          if (gap < {16'd0, dclick_ms}) mode = idb_pkg::BTN_DOUBLE;
        end else if (pressed && mode == idb_pkg::BTN_DOWN) begin
          gap = now - press_t;
          if (gap >= {16'd0, hold_ms}) mode = idb_pkg::BTN_HELD;
        end else if (!pressed && mode != idb_pkg::BTN_RELEASED) begin
          release_t = now;
          mode      = idb_pkg::BTN_RELEASED;
          pflag     = 1'b0;
        end
        want.chg_mask = sticky;
        want.chg_flag = chg;
      end
      want.stable    = stable_q;
      want.btn_state = mode;
      want.btn_flag  = pflag;
      expected_status.push_back(want);
    endfunction

    function void check_result(logic [31:0] word);
      status_word_t want;
      if (expected_status.size() == 0) begin
        $error("unexpected result %h", word);
        failures++;
        return;
      end
      want = expected_status.pop_front();
      if (word[11:0] !== want.stable) begin
        $error("stable_levels expected %h actual %h", want.stable, word[11:0]);
        failures++;
      end
      if (word[23:12] !== want.chg_mask) begin
        $error("changed_mask expected %h actual %h", want.chg_mask, word[23:12]);
        failures++;
      end
      if (word[24] !== want.chg_flag) begin
        $error("change_flag expected %b actual %b", want.chg_flag, word[24]);
        failures++;
      end
      if (word[26:25] !== want.btn_state) begin
        $error("button_state expected %0d actual %0d", want.btn_state, word[26:25]);
        failures++;
      end
      if (word[27] !== want.btn_flag) begin
        $error("button_flag expected %b actual %b", want.btn_flag, word[27]);
        failures++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [47:0]                      s_tdata = '0;
  logic                             s_tuser = idb_pkg::CMD_SAMPLE;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [31:0]                      m_tdata;
  logic                             cfg_we = 1'b0;
  logic [idb_pkg::CFG_IDX_BITS-1:0] cfg_index = idb_pkg::REG_DEBOUNCE_MS;
  logic [idb_pkg::CFG_BITS-1:0]     cfg_wdata = '0;

  debounce_tracker tracker = new();
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  logic [31:0]     t_now = '0;
  logic [11:0]     last_raw = '1;
  logic            last_btn = 1'b1;

  input_debounce_button_classifier dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  initial begin
    #2000000;
    $display("FAIL input_debounce_button_classifier");
    $finish;
  end

  // Enter and leave at a falling edge.
  task automatic send_request(logic cmd, logic [31:0] now, logic [11:0] raw, logic btn);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, btn, raw, now};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(cmd, now, raw, btn);
    @(negedge clk);
  endtask

  task automatic sample(logic [31:0] now, logic [11:0] raw, logic btn);
    send_request(idb_pkg::CMD_SAMPLE, now, raw, btn);
  endtask

  task automatic read_mask();
    send_request(idb_pkg::CMD_READ, $urandom, 12'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    int waited;
    s_tvalid <= 1'b0;
    waited = 0;
    while (tracker.pending() != 0 && waited < 100000) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [idb_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [idb_pkg::CFG_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    tracker.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_burst(int count);
    int          n;
    int          sel;
    logic [31:0] scale;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 10) begin
        read_mask();
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          t_now = $urandom;
        end else if (sel < 10) begin
          t_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end else begin
          case ($urandom_range(0, 2))
            0:       scale = {16'd0, tracker.debounce_ms};
            1:       scale = {16'd0, tracker.dclick_ms};
            default: scale = {16'd0, tracker.hold_ms};
          endcase
          t_now = t_now + $urandom_range(0, 2 * scale + 4);
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) last_raw = last_raw ^ (12'd1 << $urandom_range(0, LANES - 1));
        else if (sel < 75) last_raw = last_raw;
        else if (sel < 90) last_raw = last_raw ^ (12'd1 << $urandom_range(0, LANES - 1))
                                               ^ (12'd1 << $urandom_range(0, LANES - 1));
        else last_raw = 12'($urandom);
        if ($urandom_range(0, 99) < 30) last_btn = ~last_btn;
        sample(t_now, last_raw, last_btn);
      end
    end
  endtask

  initial begin
    int s;
    int p;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: lockout, first press near time zero, double click, hold, wrap.
    sample(32'd10, 12'h000, 1'b1);
    sample(32'd50, 12'h000, 1'b0);
    read_mask();
    read_mask();
    sample(32'd60, 12'hFFF, 1'b0);
    sample(32'd100, 12'hFFF, 1'b1);
    sample(32'd500, 12'hFFF, 1'b0);
    sample(32'd1499, 12'hFFF, 1'b0);
    sample(32'd1500, 12'hFFF, 1'b0);
    sample(32'd1600, 12'hFFF, 1'b0);
    sample(32'd1700, 12'hFFF, 1'b1);
    sample(32'd1800, 12'hFFF, 1'b0);
    sample(32'd1900, 12'hFFF, 1'b1);
    sample(32'd2000, 12'hAAA, 1'b1);
    sample(32'd2000, 12'h555, 1'b1);
    read_mask();
    sample(32'hFFFF_FFF0, 12'h555, 1'b1);
    sample(32'h0000_0010, 12'hAAA, 1'b1);
    sample(32'h0000_0022, 12'hAAA, 1'b0);
    send_request(idb_pkg::CMD_READ, 32'hFFFF_FFFF, 12'hFFF, 1'b1);
    sample(32'hFFFF_FFFF, 12'h000, 1'b1);
    read_mask();
    drain();
    t_now    = 32'hFFFF_FFFF;
    last_raw = 12'h000;
    last_btn = 1'b1;

    for (s = 0; s < 5; s++) begin
      drain();
      case (s)
        1: begin
          write_cfg(idb_pkg::REG_DEBOUNCE_MS, 16'd0);
          write_cfg(idb_pkg::REG_DCLICK_MS, 16'd0);
          write_cfg(idb_pkg::REG_HOLD_MS, 16'd0);
        end
        2: begin
          write_cfg(idb_pkg::REG_DEBOUNCE_MS, 16'hFFFF);
          write_cfg(idb_pkg::REG_DCLICK_MS, 16'hFFFF);
          write_cfg(idb_pkg::REG_HOLD_MS, 16'hFFFF);
        end
        3: begin
          // The unmapped index must not disturb anything.
          write_cfg(REG_UNMAPPED, 16'hFFFF);
          write_cfg(idb_pkg::REG_DEBOUNCE_MS, 16'd5);
          write_cfg(idb_pkg::REG_DCLICK_MS, 16'd40);
          write_cfg(idb_pkg::REG_HOLD_MS, 16'd90);
          write_cfg(REG_UNMAPPED, 16'h0000);
        end
        4: begin
          write_cfg(idb_pkg::REG_DEBOUNCE_MS, 16'($urandom_range(0, 2000)));
          write_cfg(idb_pkg::REG_DCLICK_MS, 16'($urandom));
          write_cfg(idb_pkg::REG_HOLD_MS, 16'($urandom_range(0, 3000)));
        end
        default: ;
      endcase
      for (p = 0; p < 4; p++) begin
        case (p)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 50; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 50; end
          default: begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
        random_burst(46);
      end
    end

    drain();
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("PASS input_debounce_button_classifier");
    end else begin
      $display("FAIL input_debounce_button_classifier");
    end
    $finish;
  end

endmodule
`default_nettype wire
